@@ src/tcc_pkg.sv @@
package tcc_pkg;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NUL       = 8'd0;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	// Attribute of a blank cell after reset.
	localparam logic [7:0] RESET_ATTR = 8'd7;

	// Kind of work the back end performs for one word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_READ,
		OP_READ_OOB
	} tcc_op_t;

	// One classified word as it travels from the front end to the back end.
	typedef struct packed {
		tcc_op_t    op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} tcc_item_t;

endpackage

@@ src/tcc_if.sv @@
interface tcc_cmd_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] ch;
	logic [4:0] read_row;
	logic [6:0] read_col;

	modport source (output valid, func, ch, read_row, read_col, input ready);
	modport sink (input valid, func, ch, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic       scrolled;

	modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
		input ready);
	modport sink (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
		output ready);
endinterface

@@ src/tcc_front.sv @@
module tcc_front #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	tcc_cmd_if.sink             cmd,
	output logic                push_valid,
	input  logic                push_ready,
	output tcc_pkg::tcc_item_t  push_item
);

	logic               valid_s1;
	tcc_pkg::tcc_item_t item_s1;
	tcc_pkg::tcc_item_t item_d;
	logic               in_range;

	assign cmd.ready = !valid_s1 || push_ready;

	// Bounds are checked here so the back end can tell a read inside the screen from one outside it.
	assign in_range = ({1'b0, cmd.read_row} < 6'(ROWS)) && ({1'b0, cmd.read_col} < 8'(COLS));

	always_comb begin
		item_d.ch  = cmd.ch;
		item_d.row = cmd.read_row;
		item_d.col = cmd.read_col;
		if (cmd.func) begin
			item_d.op = in_range ? tcc_pkg::OP_READ : tcc_pkg::OP_READ_OOB;
		end else begin
			case (cmd.ch)
				tcc_pkg::CH_NEWLINE:   item_d.op = tcc_pkg::OP_NEWLINE;
				tcc_pkg::CH_BACKSPACE: item_d.op = tcc_pkg::OP_BACKSPACE;
				tcc_pkg::CH_NUL:       item_d.op = tcc_pkg::OP_NOP;
				default:               item_d.op = tcc_pkg::OP_PUT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

@@ src/tcc_queue.sv @@
module tcc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  tcc_pkg::tcc_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output tcc_pkg::tcc_item_t pop_item
);

	tcc_pkg::tcc_item_t slots_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ src/tcc_back.sv @@
module tcc_back #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  tcc_pkg::tcc_item_t q_item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	tcc_rsp_if.source          rsp
);

	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (2 ** CW);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_READ,
		ST_BLANK
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [RW-1:0]   top_q;
	logic [CW-1:0]   sweep_col_q;
	logic [RW-1:0]   sweep_row_q;
	logic [7:0]      text_attr_q;
	logic            rsp_valid_q;
	logic [7:0]      rsp_char_q;
	logic [7:0]      rsp_attr_q;
	logic [6:0]      rsp_col_q;
	logic [4:0]      rsp_row_q;
	logic            rsp_scrolled_q;

	logic [15:0]     mem_q [DEPTH];
	logic [15:0]     rd_data_q;

	logic            pop;
	logic            rsp_load;
	logic [CW-1:0]   nxt_col;
	logic [RW-1:0]   nxt_row;
	logic            nxt_scroll;
	logic            wrap;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [15:0]     mem_wdata;
	logic [AW-1:0]   rd_addr;
	logic [RW-1:0]   top_next;

	// Screen rows live in the store as a ring; top_q is the stored row shown as row 0.
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (RW+1)'(ROWS)) begin
			s = s - (RW+1)'(ROWS);
		end
		return s[RW-1:0];
	endfunction

	assign pop      = (state_q == ST_RUN) && q_valid && (!rsp_valid_q || rsp.ready);
	assign q_ready  = pop;
	// A result is loaded at the end of a read, or when any other word is run.
	assign rsp_load = (state_q == ST_READ) || (pop && (q_item.op != tcc_pkg::OP_READ));
	assign top_next = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
	assign rd_addr  = {phys_row(q_item.row[RW-1:0], top_q), q_item.col[CW-1:0]};

	always_comb begin
		nxt_col    = col_q;
		nxt_row    = row_q;
		nxt_scroll = 1'b0;
		wrap       = 1'b0;
		case (q_item.op)
			tcc_pkg::OP_NEWLINE: begin
				wrap = 1'b1;
			end
			tcc_pkg::OP_BACKSPACE: begin
				if (col_q != '0) begin
					nxt_col = col_q - 1'b1;
				end else if (row_q != '0) begin
					nxt_col = COL_LAST;
					nxt_row = row_q - 1'b1;
				end
			end
			tcc_pkg::OP_PUT: begin
				if (col_q != COL_LAST) begin
					nxt_col = col_q + 1'b1;
				end else begin
					wrap = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (wrap) begin
			nxt_col = '0;
			if (row_q == ROW_LAST) begin
				nxt_scroll = 1'b1;
			end else begin
				nxt_row = row_q + 1'b1;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {phys_row(row_q, top_q), col_q};
		mem_wdata = {text_attr_q, q_item.ch};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {sweep_row_q, sweep_col_q};
				mem_wdata = {tcc_pkg::RESET_ATTR, tcc_pkg::CH_SPACE};
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = {sweep_row_q, sweep_col_q};
				mem_wdata = {text_attr_q, tcc_pkg::CH_SPACE};
			end
			ST_RUN: begin
				mem_we = pop && (q_item.op == tcc_pkg::OP_PUT);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			col_q          <= '0;
			row_q          <= '0;
			top_q          <= '0;
			sweep_col_q    <= '0;
			sweep_row_q    <= '0;
			text_attr_q    <= tcc_pkg::RESET_ATTR;
			rsp_valid_q    <= 1'b0;
			rsp_char_q     <= '0;
			rsp_attr_q     <= '0;
			rsp_col_q      <= '0;
			rsp_row_q      <= '0;
			rsp_scrolled_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_attr_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sweep_col_q == COL_LAST) begin
						sweep_col_q <= '0;
						if (sweep_row_q == ROW_LAST) begin
							state_q <= ST_RUN;
						end else begin
							sweep_row_q <= sweep_row_q + 1'b1;
						end
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (sweep_col_q == COL_LAST) begin
						state_q <= ST_RUN;
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (pop) begin
						if (q_item.op == tcc_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else begin
							rsp_char_q     <= '0;
							rsp_attr_q     <= '0;
							rsp_col_q      <= 7'(nxt_col);
							rsp_row_q      <= 5'(nxt_row);
							rsp_scrolled_q <= nxt_scroll;
							col_q          <= nxt_col;
							row_q          <= nxt_row;
							if (nxt_scroll) begin
								// The old top row becomes the new bottom row and is blanked.
								top_q       <= top_next;
								sweep_row_q <= top_q;
								sweep_col_q <= '0;
								state_q     <= ST_BLANK;
							end
						end
					end
				end
				ST_READ: begin
					rsp_char_q     <= rd_data_q[7:0];
					rsp_attr_q     <= rd_data_q[15:8];
					rsp_col_q      <= 7'(col_q);
					rsp_row_q      <= 5'(row_q);
					rsp_scrolled_q <= 1'b0;
					state_q        <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_char  = rsp_char_q;
	assign rsp.cell_attr  = rsp_attr_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.scrolled   = rsp_scrolled_q;

endmodule

@@ src/text_console_cursor_scroll.sv @@
// Path: front-end register, queue slot, output register; reads add the store read register
// and the read state. Throughput: one word per cycle for puts, newlines and backspaces that
// do not scroll, while results are taken; a read holds the back end in its read state, a
// scroll while its row is blanked. Reset: asynchronous, active low; the cursor goes home, the
// attribute returns to 7, and a clearing pass blanks the screen before any word is run.
module text_console_cursor_scroll #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	tcc_cmd_if.sink    cmd,
	tcc_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	// The front end registers each incoming word and sorts it into one of a few
	// operations: put, newline, backspace, ignored zero byte, or a read that is
	// already known to fall inside or outside the screen. It can keep taking
	// words while the back end is busy blanking a row, until the queue fills.
	logic               push_valid;
	logic               push_ready;
	tcc_pkg::tcc_item_t push_item;

	// The queue holds two classified words between the two halves.
	logic               q_valid;
	logic               q_ready;
	tcc_pkg::tcc_item_t q_item;

	tcc_front #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	tcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// The back end owns the cursor, the attribute register and the screen store.
	// The store is kept as a ring of rows, so a scroll only advances the top-row
	// pointer and then blanks the one row that has come into view at the bottom,
	// one cell per cycle. Results leave through an output register; the next word
	// is started only once the previous result is taken, possibly in that same cycle.
	tcc_back #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule
